### hdl/ctdc_pkg.sv
// Shared types, codes and constants of the calibrated dBm converter.
package ctdc_pkg;

  // Field widths
  localparam int READING_W   = 16;
  localparam int INDEX_W     = 4;
  localparam int COUNT_W     = 5;
  localparam int DBM_W       = 12;
  localparam int CFG_INDEX_W = 2;
  // |offset| * 50 + span / 2 stays below 2^22
  localparam int DIVIDEND_W  = 22;
  // Working width of the level arithmetic
  localparam int LVL_W       = 24;

  // Level constants in tenths of dBm
  localparam logic signed [LVL_W-1:0] TOP_TENTHS   = -24'sd400;
  localparam logic signed [LVL_W-1:0] STEP_TENTHS  = 24'sd50;
  localparam logic signed [LVL_W-1:0] CAP_TENTHS   = -24'sd350;
  localparam logic signed [LVL_W-1:0] FLOOR_TENTHS = -24'sd1200;
  localparam logic signed [DBM_W-1:0] ERROR_TENTHS = -12'sd1990;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POINT_COUNT_SECOND = 2'd1;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_CONVERT = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_PREP,
    ST_DIV
  } state_t;

  typedef struct packed {
    op_t                  op;
    logic                 channel;
    logic [INDEX_W-1:0]   point_index;
    logic [READING_W-1:0] cal_value;
    logic [READING_W-1:0] reading;
  } in_item_t;

  typedef struct packed {
    logic signed [DBM_W-1:0] dbm_tenths;
    logic                    table_error;
  } out_item_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [READING_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

### hdl/ctdc_point_ram.sv
// Calibration point memory: one write port, one registered read port.
module ctdc_point_ram
  import ctdc_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [READING_W-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [READING_W-1:0] rd_data
);

  logic [READING_W-1:0] mem [DEPTH];
  logic [READING_W-1:0] rd_data_r;

  // Write one point, read one point every cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### hdl/ctdc_divider.sv
// Restoring divider, one quotient bit per cycle.
module ctdc_divider
  import ctdc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  active_r, active_nxt;
  logic                  done_r, done_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [READING_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] dq_r, dq_nxt;
  logic [READING_W-1:0]  dvs_r, dvs_nxt;
  logic [READING_W:0]    shifted;
  logic [READING_W:0]    diff;
  logic                  fits;

  // Trial subtraction of the divisor from the shifted remainder
  assign shifted = {rem_r, dq_r[DIVIDEND_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  // Load on start, then iterate one bit per cycle
  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    dq_nxt     = dq_r;
    dvs_nxt    = dvs_r;
    if (req.start) begin
      active_nxt = 1'b1;
      cnt_nxt    = CNT_W'(DIVIDEND_W);
      rem_nxt    = '0;
      dq_nxt     = req.dividend;
      dvs_nxt    = req.divisor;
    end else if (active_r) begin
      rem_nxt = fits ? diff[READING_W-1:0] : shifted[READING_W-1:0];
      dq_nxt  = {dq_r[DIVIDEND_W-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule

### hdl/cal_table_dbm_converter_core.sv
// Top level: calibrated detector reading to tenths of dBm converter.
// A load transaction (op = load) writes one calibration point in the cycle it is accepted and
// keeps busy low. A convert transaction walks the channel's points one per cycle out of the
// point memory; when it finds a usable interval it forms the interpolation terms in the prep
// state and runs the serial divider (22 quotient bits, one per cycle, then a done strobe). An
// unusable table ends the transaction with the walk, also when the point count is zero. busy
// stays high until the result is out. The result is on out_data for exactly one cycle with
// out_valid high, in the cycle busy falls; the receiver cannot stall it.
// Configuration writes are taken while busy is low.
module cal_table_dbm_converter_core
  import ctdc_pkg::*;
#(
  parameter int POINTS_PER_CHANNEL = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_data,
  output logic                   out_valid,
  output out_item_t              out_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]     cfg_data
);

  localparam int KW    = $clog2(POINTS_PER_CHANNEL);
  localparam int AW    = $clog2(2 * POINTS_PER_CHANNEL);
  localparam int DEPTH = 2 * POINTS_PER_CHANNEL;

  state_t state_r, state_nxt;

  logic [COUNT_W-1:0]   count_first_r, count_second_r;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_data_r, out_data_nxt;

  logic [READING_W-1:0] value_r, value_nxt;
  logic                 ch_r, ch_nxt;
  logic [KW-1:0]        k_r, k_nxt;
  logic [KW-1:0]        last_k_r, last_k_nxt;
  logic                 cnt_zero_r, cnt_zero_nxt;
  logic [READING_W-1:0] lower_r, lower_nxt;
  logic [READING_W-1:0] upper_r, upper_nxt;
  logic                 paired_r, paired_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [LVL_W-1:0] base_r, base_nxt;

  logic                 accept;
  logic                 mem_we;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;
  logic [READING_W-1:0] rd_data;

  logic [COUNT_W-1:0]   cnt_sel;
  logic [COUNT_W:0]     cnt_ext;
  logic [COUNT_W:0]     cnt_eff;

  logic [READING_W-1:0] walk_upper, walk_lower;
  logic                 walk_paired, walk_stop, walk_ok, walk_good;

  logic                 neg_now;
  logic [READING_W-1:0] off_abs;
  logic [READING_W-1:0] span;
  logic signed [LVL_W-1:0] quo_ext, level_sum, level_clamped;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = !busy;

  // Point memory write: a load transaction with an index inside the table
  assign mem_we  = accept && (in_data.op == OP_LOAD) &&
                   ({2'b00, in_data.point_index} < 6'(POINTS_PER_CHANNEL));
  assign wr_addr = (in_data.channel ? AW'(POINTS_PER_CHANNEL) : AW'(0)) +
                   AW'(in_data.point_index);

  // Read the first point at accept, then the following point each walk cycle
  always_comb begin
    if (state_r == ST_IDLE) begin
      rd_addr = in_data.channel ? AW'(POINTS_PER_CHANNEL) : AW'(0);
    end else begin
      rd_addr = (ch_r ? AW'(POINTS_PER_CHANNEL) : AW'(0)) + AW'(KW'(k_r + 1'b1));
    end
  end

  ctdc_point_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_addr),
    .wr_data (in_data.cal_value),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Saturate the channel's point count to the table size
  assign cnt_sel = in_data.channel ? count_second_r : count_first_r;
  assign cnt_ext = {1'b0, cnt_sel};
  assign cnt_eff = (cnt_ext > (COUNT_W+1)'(POINTS_PER_CHANNEL)) ?
                   (COUNT_W+1)'(POINTS_PER_CHANNEL) : cnt_ext;

  // Evaluate the point just read against the running interval
  always_comb begin
    walk_lower  = rd_data;
    walk_upper  = upper_r;
    walk_paired = paired_r;
    walk_stop   = 1'b0;
    walk_ok     = 1'b0;
    if (lower_r != '0) begin
      walk_upper  = lower_r;
      walk_paired = 1'b1;
      if (value_r >= rd_data) begin
        walk_stop = 1'b1;
        walk_ok   = 1'b1;
      end else if (lower_r <= rd_data) begin
        walk_stop = 1'b1;
      end
    end
    if (!walk_stop && (k_r == last_k_r)) begin
      walk_stop = 1'b1;
      walk_ok   = (k_r == KW'(POINTS_PER_CHANNEL - 1));
    end
    if (cnt_zero_r) begin
      walk_stop = 1'b1;
      walk_ok   = 1'b0;
    end
    walk_good = walk_ok && walk_paired && (walk_upper > walk_lower);
  end

  // Interpolation terms: rounded magnitude quotient, sign applied afterwards
  assign neg_now = (value_r < lower_r);
  assign off_abs = neg_now ? (lower_r - value_r) : (value_r - lower_r);
  assign span    = upper_r - lower_r;

  assign div_req.start    = (state_r == ST_PREP);
  assign div_req.dividend = DIVIDEND_W'(off_abs) * DIVIDEND_W'(STEP_TENTHS) +
                            DIVIDEND_W'(span >> 1);
  assign div_req.divisor  = span;

  ctdc_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Apply the quotient to the point level and clamp
  assign quo_ext   = LVL_W'(div_rsp.quotient);
  assign level_sum = neg_r ? (base_r - quo_ext) : (base_r + quo_ext);
  always_comb begin
    level_clamped = level_sum;
    if (!neg_r && (level_sum > CAP_TENTHS)) begin
      level_clamped = CAP_TENTHS;
    end else if (neg_r && (level_sum < FLOOR_TENTHS)) begin
      level_clamped = FLOOR_TENTHS;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.op == OP_CONVERT)) begin
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_stop) begin
          state_nxt = walk_good ? ST_PREP : ST_IDLE;
        end
      end
      ST_PREP: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and result updates per state
  always_comb begin
    value_nxt     = value_r;
    ch_nxt        = ch_r;
    k_nxt         = k_r;
    last_k_nxt    = last_k_r;
    cnt_zero_nxt  = cnt_zero_r;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    paired_nxt    = paired_r;
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.op == OP_CONVERT)) begin
          value_nxt    = in_data.reading;
          ch_nxt       = in_data.channel;
          k_nxt        = '0;
          last_k_nxt   = KW'(cnt_eff - 1'b1);
          cnt_zero_nxt = (cnt_eff == '0);
          lower_nxt    = '0;
          upper_nxt    = '0;
          paired_nxt   = 1'b0;
        end
      end
      ST_WALK: begin
        lower_nxt  = walk_lower;
        upper_nxt  = walk_upper;
        paired_nxt = walk_paired;
        if (!walk_stop) begin
          k_nxt = KW'(k_r + 1'b1);
        end else if (!walk_good) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.dbm_tenths  = ERROR_TENTHS;
          out_data_nxt.table_error = 1'b1;
        end
      end
      ST_PREP: begin
        neg_nxt  = neg_now;
        base_nxt = TOP_TENTHS - STEP_TENTHS * LVL_W'(k_r);
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.dbm_tenths  = DBM_W'(level_clamped);
          out_data_nxt.table_error = 1'b0;
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      count_first_r  <= '0;
      count_second_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_POINT_COUNT_FIRST:  count_first_r  <= cfg_data;
          CFG_POINT_COUNT_SECOND: count_second_r <= cfg_data;
          default: begin
            count_first_r <= count_first_r;
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    ch_r       <= ch_nxt;
    k_r        <= k_nxt;
    last_k_r   <= last_k_nxt;
    cnt_zero_r <= cnt_zero_nxt;
    lower_r    <= lower_nxt;
    upper_r    <= upper_nxt;
    paired_r   <= paired_nxt;
    neg_r      <= neg_nxt;
    base_r     <= base_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Results of two transactions never land in adjacent cycles
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // An accepted convert always raises busy
  a_convert_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_data.op == OP_CONVERT)) |=> busy)
    else $error("convert transaction did not raise busy");

  // The divider finishes only while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside the divide state");

  // A good result lies between the floor and the cap
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.table_error) |->
      ((out_data.dbm_tenths >= -12'sd1200) && (out_data.dbm_tenths <= -12'sd350)))
    else $error("converted level out of range");

  // An error result carries the error level
  a_error_level: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.table_error) |-> (out_data.dbm_tenths == ERROR_TENTHS))
    else $error("error result with wrong level");

endmodule
